// File: design/depth_pid_thruster_mixer_top_assert.svh
// Assertion macros for the depth PID thruster mixer.
// Included by the modules that check their own logic; uses clk and arst_n of the includer.
`ifndef DEPTH_PID_THRUSTER_MIXER_TOP_ASSERT_SVH
`define DEPTH_PID_THRUSTER_MIXER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DPTM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DPTM_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) trig |=> prop) else $error(msg);
`else
`define DPTM_ASSERT(lbl, prop, msg)
`define DPTM_ASSERT_NEXT(lbl, trig, prop, msg)
`endif
`endif

// File: design/dptm_pkg.sv
// Shared types, widths and constants of the depth PID thruster mixer.
// No dependencies; every module takes names from here by scope.
package dptm_pkg;

	localparam int DT_STEPS        = 50;
	localparam int MM_PER_M        = 1000;
	localparam int PWM_CENTER      = 1500;
	localparam int SETPOINT_ARM_MM = -200;
	localparam int OUT_SCALE       = 256000000;

	localparam int DEPTH_W    = 20;
	localparam int SETPOINT_W = 18;
	localparam int GAIN_W     = 24;
	localparam int ICLAMP_W   = 20;
	localparam int VLIM_W     = 24;
	localparam int ELIM_W     = 9;
	localparam int EFFORT_W   = 10;
	localparam int THRUST_W   = 11;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	localparam int NUM_STAGES = 7;

	localparam int ERR_W      = DEPTH_W + 1;
	localparam int DIFF_MAG_W = DEPTH_W;
	localparam int DIFFK_W    = 30;
	localparam int DT_L       = $clog2(DT_STEPS);
	localparam int DT_W       = $clog2(DT_STEPS + 1);

	localparam int VEL_SHIFT   = DIFFK_W + DT_L;
	localparam int VEL_RECIP_W = DIFFK_W + 1;
	localparam int VEL_PROD_W  = DIFFK_W + VEL_RECIP_W;
	localparam logic [63:0] VEL_RECIP64 =
		((64'd1 << VEL_SHIFT) + 64'(DT_STEPS) - 64'd1) / 64'(DT_STEPS);
	localparam logic [VEL_RECIP_W-1:0] VEL_RECIP = VEL_RECIP_W'(VEL_RECIP64);

	localparam int PROD_W   = GAIN_W + ERR_W;
	localparam int KPK_W    = PROD_W + 10;
	localparam int INC_W    = PROD_W + DT_W;
	localparam int ACC_W    = INC_W + 1;
	localparam int INTEG_W  = 32;
	localparam int KDV_W    = 2 * VLIM_W;
	localparam int SUM_W    = 56;

	localparam int OUT_SHIFT   = 14;
	localparam int OUT_ODD     = OUT_SCALE / (1 << OUT_SHIFT);
	localparam int SCALED_W    = SUM_W - OUT_SHIFT;
	localparam int Q_W         = EFFORT_W;
	localparam int Q_SAT       = 1 << (EFFORT_W - 1);
	localparam int X_SAT       = Q_SAT * OUT_ODD;
	localparam int DIV_N       = $clog2(X_SAT);
	localparam int DIV_L       = $clog2(OUT_ODD);
	localparam int DIV_RECIP_W = DIV_N + 1;
	localparam int DIV_PROD_W  = DIV_N + DIV_RECIP_W;
	localparam logic [63:0] DIV_RECIP64 =
		((64'd1 << (DIV_N + DIV_L)) + 64'(OUT_ODD) - 64'd1) / 64'(OUT_ODD);
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_W'(DIV_RECIP64);

	localparam int THRUST_SUM_W = THRUST_W + 1;
	localparam logic [THRUST_SUM_W-1:0] THRUST_SUM = THRUST_SUM_W'(2 * PWM_CENTER);

	localparam logic signed [SETPOINT_W-1:0] RST_SETPOINT  = -18'sd500;
	localparam logic signed [GAIN_W-1:0]     RST_KP        = 24'sd76800;
	localparam logic signed [GAIN_W-1:0]     RST_KI        = 24'sd0;
	localparam logic signed [GAIN_W-1:0]     RST_KD        = 24'sd0;
	localparam logic signed [ICLAMP_W-1:0]   RST_IMIN      = -20'sd179200;
	localparam logic signed [ICLAMP_W-1:0]   RST_IMAX      = -20'sd153600;
	localparam logic [VLIM_W-1:0]            RST_VLIM      = 24'd1000000;
	localparam logic [ELIM_W-1:0]            RST_ELIM      = 9'd150;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT = 3'd0,
		REG_KP       = 3'd1,
		REG_KI       = 3'd2,
		REG_KD       = 3'd3,
		REG_IMIN     = 3'd4,
		REG_IMAX     = 3'd5,
		REG_VLIM     = 3'd6,
		REG_ELIM     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SETPOINT_W-1:0] setpoint_mm;
		logic signed [GAIN_W-1:0]     kp_gain;
		logic signed [GAIN_W-1:0]     ki_gain;
		logic signed [GAIN_W-1:0]     kd_gain;
		logic signed [ICLAMP_W-1:0]   integral_min;
		logic signed [ICLAMP_W-1:0]   integral_max;
		logic [VLIM_W-1:0]            velocity_limit;
		logic [ELIM_W-1:0]            effort_limit;
	} cfg_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] ld;
		logic [NUM_STAGES-1:0] v;
	} pipe_ctl_t;

	typedef struct packed {
		logic signed [KPK_W-1:0]   kp_k;
		logic signed [INTEG_W-1:0] integ;
		logic signed [KDV_W-1:0]   kdv;
	} front_t;

endpackage

// File: design/depth_pid_thruster_mixer_top.sv
// Top level of the depth PID thruster mixer.
// Depends on dptm_pkg, dptm_cfg, dptm_ctl, dptm_front and dptm_back.
//
// Takes one depth word per clock when the result side does not stall and returns one effort
// word with four thruster values. Seven registered stages with their own valid bits let
// bubbles close up, so a new sample enters while an older result still waits. The
// sustained rate of one word per cycle is set by the integral register, whose add and
// clamp close combinationally in the fourth stage.
module depth_pid_thruster_mixer_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dptm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dptm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic signed [dptm_pkg::DEPTH_W-1:0]   depth_mm,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [dptm_pkg::EFFORT_W-1:0]  effort,
	output logic [dptm_pkg::THRUST_W-1:0]         thruster_a,
	output logic [dptm_pkg::THRUST_W-1:0]         thruster_b,
	output logic [dptm_pkg::THRUST_W-1:0]         thruster_c,
	output logic [dptm_pkg::THRUST_W-1:0]         thruster_d
);

	dptm_pkg::cfg_t      cfg;
	dptm_pkg::pipe_ctl_t ctl;
	dptm_pkg::front_t    front;

	dptm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dptm_ctl u_ctl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ctl          (ctl)
	);

	dptm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.ctl      (ctl),
		.depth_mm (depth_mm),
		.front    (front)
	);

	dptm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.effort_limit (cfg.effort_limit),
		.ctl          (ctl),
		.front        (front),
		.effort       (effort),
		.thruster_a   (thruster_a),
		.thruster_b   (thruster_b),
		.thruster_c   (thruster_c),
		.thruster_d   (thruster_d)
	);

endmodule

// File: design/dptm_cfg.sv
// Configuration register file of the depth PID thruster mixer.
// Depends on dptm_pkg for the register map and the cfg_t layout.
module dptm_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dptm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dptm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output dptm_pkg::cfg_t                      cfg
);

	dptm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint_mm    <= dptm_pkg::RST_SETPOINT;
			cfg_q.kp_gain        <= dptm_pkg::RST_KP;
			cfg_q.ki_gain        <= dptm_pkg::RST_KI;
			cfg_q.kd_gain        <= dptm_pkg::RST_KD;
			cfg_q.integral_min   <= dptm_pkg::RST_IMIN;
			cfg_q.integral_max   <= dptm_pkg::RST_IMAX;
			cfg_q.velocity_limit <= dptm_pkg::RST_VLIM;
			cfg_q.effort_limit   <= dptm_pkg::RST_ELIM;
		end else if (cfg_we) begin
			unique case (dptm_pkg::cfg_reg_t'(cfg_index))
				dptm_pkg::REG_SETPOINT: cfg_q.setpoint_mm <= cfg_data[dptm_pkg::SETPOINT_W-1:0];
				dptm_pkg::REG_KP:       cfg_q.kp_gain <= cfg_data[dptm_pkg::GAIN_W-1:0];
				dptm_pkg::REG_KI:       cfg_q.ki_gain <= cfg_data[dptm_pkg::GAIN_W-1:0];
				dptm_pkg::REG_KD:       cfg_q.kd_gain <= cfg_data[dptm_pkg::GAIN_W-1:0];
				dptm_pkg::REG_IMIN:     cfg_q.integral_min <= cfg_data[dptm_pkg::ICLAMP_W-1:0];
				dptm_pkg::REG_IMAX:     cfg_q.integral_max <= cfg_data[dptm_pkg::ICLAMP_W-1:0];
				dptm_pkg::REG_VLIM:     cfg_q.velocity_limit <= cfg_data[dptm_pkg::VLIM_W-1:0];
				dptm_pkg::REG_ELIM:     cfg_q.effort_limit <= cfg_data[dptm_pkg::ELIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/dptm_ctl.sv
// Pipeline flow control: per-stage valid bits and load enables.
// Depends on dptm_pkg for the stage count and pipe_ctl_t.
module dptm_ctl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	output logic                  result_valid,
	input  logic                  result_stall,
	output dptm_pkg::pipe_ctl_t   ctl
);

	localparam int NS = dptm_pkg::NUM_STAGES;

	logic [NS-1:0] v_q;
	logic [NS-1:0] free;
	logic [NS-1:0] leave;
	logic [NS-1:0] ld;

	always_comb begin
		leave[NS-1] = v_q[NS-1] && !result_stall;
		free[NS-1]  = !v_q[NS-1] || leave[NS-1];
		for (int k = NS - 2; k >= 0; k--) begin
			leave[k] = v_q[k] && free[k+1];
			free[k]  = !v_q[k] || leave[k];
		end
		ld[0] = sample_valid && free[0];
		for (int k = 1; k < NS; k++) begin
			ld[k] = leave[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= ld | (v_q & ~leave);
		end
	end

	assign sample_stall = !free[0];
	assign result_valid = v_q[NS-1];
	assign ctl.ld       = ld;
	assign ctl.v        = v_q;

endmodule

// File: design/dptm_front.sv
// Front half of the pipeline: error, velocity estimate, P and D products, integral state.
// Depends on dptm_pkg and the assertion macro header.
`include "depth_pid_thruster_mixer_top_assert.svh"
module dptm_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dptm_pkg::cfg_t                       cfg,
	input  dptm_pkg::pipe_ctl_t                  ctl,
	input  logic signed [dptm_pkg::DEPTH_W-1:0]  depth_mm,
	output dptm_pkg::front_t                     front
);

	localparam int ERR_W      = dptm_pkg::ERR_W;
	localparam int DIFF_MAG_W = dptm_pkg::DIFF_MAG_W;
	localparam int DIFFK_W    = dptm_pkg::DIFFK_W;
	localparam int PROD_W     = dptm_pkg::PROD_W;
	localparam int KPK_W      = dptm_pkg::KPK_W;
	localparam int INC_W      = dptm_pkg::INC_W;
	localparam int ACC_W      = dptm_pkg::ACC_W;
	localparam int INTEG_W    = dptm_pkg::INTEG_W;
	localparam int KDV_W      = dptm_pkg::KDV_W;
	localparam int VLIM_W     = dptm_pkg::VLIM_W;
	localparam int VPW        = dptm_pkg::VEL_PROD_W;

	logic signed [dptm_pkg::DEPTH_W-1:0] prev_q;
	logic signed [INTEG_W-1:0]           integ_q;

	logic signed [ERR_W-1:0]      err_s1;
	logic [DIFFK_W-1:0]           diffk_s1;
	logic                         dneg_s1;
	logic signed [PROD_W-1:0]     kp_err_s2;
	logic signed [PROD_W-1:0]     ki_err_s2;
	logic [DIFFK_W-1:0]           vel_s2;
	logic                         dneg_s2;
	logic signed [KPK_W-1:0]      kp_k_s3;
	logic signed [INC_W-1:0]      inc_s3;
	logic signed [KDV_W-1:0]      kdv_mag_s3;
	logic                         dneg_s3;
	logic signed [KPK_W-1:0]      kp_k_s4;
	logic signed [INTEG_W-1:0]    integ_s4;
	logic signed [KDV_W-1:0]      kdv_s4;

	logic signed [ERR_W-1:0]      err;
	logic signed [ERR_W-1:0]      diff;
	logic [DIFF_MAG_W-1:0]        diff_mag;
	logic [DIFFK_W-1:0]           diffk;
	logic [VPW-1:0]               vel_prod;
	logic [VLIM_W-1:0]            vclamp;
	logic signed [ACC_W-1:0]      acc;
	logic signed [ACC_W-1:0]      imin_k;
	logic signed [ACC_W-1:0]      imax_k;
	logic signed [ACC_W-1:0]      acc_lo;
	logic signed [ACC_W-1:0]      acc_cl;
	logic signed [INTEG_W-1:0]    integ_next;
	logic                         ki_nz;
	logic                         armed;

	always_comb begin
		err      = ERR_W'(cfg.setpoint_mm) - ERR_W'(depth_mm);
		diff     = ERR_W'(depth_mm) - ERR_W'(prev_q);
		diff_mag = DIFF_MAG_W'(diff[ERR_W-1] ? -diff : diff);
		diffk    = DIFFK_W'(diff_mag) * DIFFK_W'(dptm_pkg::MM_PER_M);
		vel_prod = VPW'(diffk_s1) * VPW'(dptm_pkg::VEL_RECIP);
		vclamp   = (vel_s2 > DIFFK_W'(cfg.velocity_limit)) ? cfg.velocity_limit
			: VLIM_W'(vel_s2);
		ki_nz    = (cfg.ki_gain != '0);
		armed    = (cfg.setpoint_mm < dptm_pkg::SETPOINT_ARM_MM);
		acc      = ACC_W'(integ_q) + ACC_W'(inc_s3);
		imin_k   = ACC_W'(cfg.integral_min) * ACC_W'(dptm_pkg::MM_PER_M);
		imax_k   = ACC_W'(cfg.integral_max) * ACC_W'(dptm_pkg::MM_PER_M);
		acc_lo   = (acc < imin_k) ? imin_k : acc;
		acc_cl   = (acc_lo > imax_k) ? imax_k : acc_lo;
		if (!ki_nz) begin
			integ_next = '0;
		end else if (armed) begin
			integ_next = INTEG_W'(acc_cl);
		end else begin
			integ_next = integ_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
		end else begin
			if (ctl.ld[0]) begin
				prev_q <= depth_mm;
			end
			if (ctl.ld[3]) begin
				integ_q <= integ_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[0]) begin
			err_s1   <= err;
			diffk_s1 <= diffk;
			dneg_s1  <= diff[ERR_W-1];
		end
		if (ctl.ld[1]) begin
			kp_err_s2 <= PROD_W'(cfg.kp_gain) * PROD_W'(err_s1);
			ki_err_s2 <= PROD_W'(cfg.ki_gain) * PROD_W'(err_s1);
			vel_s2    <= DIFFK_W'(vel_prod >> dptm_pkg::VEL_SHIFT);
			dneg_s2   <= dneg_s1;
		end
		if (ctl.ld[2]) begin
			kp_k_s3    <= KPK_W'(kp_err_s2) * KPK_W'(dptm_pkg::MM_PER_M);
			inc_s3     <= INC_W'(ki_err_s2) * INC_W'(dptm_pkg::DT_STEPS);
			kdv_mag_s3 <= KDV_W'(cfg.kd_gain) * KDV_W'($signed({1'b0, vclamp}));
			dneg_s3    <= dneg_s2;
		end
		if (ctl.ld[3]) begin
			kp_k_s4  <= kp_k_s3;
			integ_s4 <= integ_next;
			kdv_s4   <= dneg_s3 ? -kdv_mag_s3 : kdv_mag_s3;
		end
	end

	assign front.kp_k  = kp_k_s4;
	assign front.integ = integ_s4;
	assign front.kdv   = kdv_s4;

	`DPTM_ASSERT_NEXT(a_integ_upper, (ctl.ld[3] && ki_nz && armed), (ACC_W'(integ_q) <= $past(imax_k)), "integral above upper clamp")
	`DPTM_ASSERT_NEXT(a_integ_clear, (ctl.ld[3] && !ki_nz), (integ_q == '0), "integral not cleared with zero gain")

endmodule

// File: design/dptm_back.sv
// Back half of the pipeline: sum, scale to whole PWM counts, saturate and mix.
// Depends on dptm_pkg and the assertion macro header.
`include "depth_pid_thruster_mixer_top_assert.svh"
module dptm_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [dptm_pkg::ELIM_W-1:0]           effort_limit,
	input  dptm_pkg::pipe_ctl_t                   ctl,
	input  dptm_pkg::front_t                      front,
	output logic signed [dptm_pkg::EFFORT_W-1:0]  effort,
	output logic [dptm_pkg::THRUST_W-1:0]         thruster_a,
	output logic [dptm_pkg::THRUST_W-1:0]         thruster_b,
	output logic [dptm_pkg::THRUST_W-1:0]         thruster_c,
	output logic [dptm_pkg::THRUST_W-1:0]         thruster_d
);

	localparam int SUM_W    = dptm_pkg::SUM_W;
	localparam int SCALED_W = dptm_pkg::SCALED_W;
	localparam int DIV_N    = dptm_pkg::DIV_N;
	localparam int DPW      = dptm_pkg::DIV_PROD_W;
	localparam int Q_W      = dptm_pkg::Q_W;
	localparam int EFFORT_W = dptm_pkg::EFFORT_W;
	localparam int THRUST_W = dptm_pkg::THRUST_W;
	localparam int TSW      = dptm_pkg::THRUST_SUM_W;

	logic signed [SUM_W-1:0]    sum_s5;
	logic [Q_W-1:0]             q_s6;
	logic                       neg_s6;
	logic signed [EFFORT_W-1:0] effort_q;
	logic [THRUST_W-1:0]        thr_a_q;
	logic [THRUST_W-1:0]        thr_b_q;

	logic [SUM_W-1:0]           smag;
	logic [SCALED_W-1:0]        x;
	logic [DPW-1:0]             div_prod;
	logic [Q_W-1:0]             q;
	logic [Q_W-1:0]             qc;
	logic signed [EFFORT_W-1:0] eff;

	always_comb begin
		smag     = SUM_W'(sum_s5[SUM_W-1] ? -sum_s5 : sum_s5);
		x        = SCALED_W'(smag >> dptm_pkg::OUT_SHIFT);
		div_prod = DPW'(x[DIV_N-1:0]) * DPW'(dptm_pkg::DIV_RECIP);
		if (x >= SCALED_W'(dptm_pkg::X_SAT)) begin
			q = Q_W'(dptm_pkg::Q_SAT);
		end else begin
			q = Q_W'(div_prod >> (dptm_pkg::DIV_N + dptm_pkg::DIV_L));
		end
		qc  = (q_s6 > Q_W'(effort_limit)) ? Q_W'(effort_limit) : q_s6;
		eff = neg_s6 ? -$signed(qc) : $signed(qc);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[4]) begin
			sum_s5 <= SUM_W'(front.kp_k)
				+ SUM_W'(front.integ) * SUM_W'(dptm_pkg::MM_PER_M)
				+ SUM_W'(front.kdv);
		end
		if (ctl.ld[5]) begin
			q_s6   <= q;
			neg_s6 <= sum_s5[SUM_W-1];
		end
		if (ctl.ld[6]) begin
			effort_q <= eff;
			thr_a_q  <= THRUST_W'(dptm_pkg::PWM_CENTER) + THRUST_W'(eff);
			thr_b_q  <= THRUST_W'(dptm_pkg::PWM_CENTER) - THRUST_W'(eff);
		end
	end

	assign effort     = effort_q;
	assign thruster_a = thr_a_q;
	assign thruster_b = thr_b_q;
	assign thruster_c = thr_b_q;
	assign thruster_d = thr_a_q;

	`DPTM_ASSERT(a_mix_center, (ctl.v[dptm_pkg::NUM_STAGES-1] |-> ((TSW'(thr_a_q) + TSW'(thr_b_q)) == dptm_pkg::THRUST_SUM)), "thruster pair not centered")
	`DPTM_ASSERT(a_mix_effort, (ctl.v[dptm_pkg::NUM_STAGES-1] |-> (thr_a_q == THRUST_W'(dptm_pkg::PWM_CENTER) + THRUST_W'(effort_q))), "thruster does not follow effort")

endmodule
